// File: hdl/point_rigid_transform_quantize_assert.svh
// Assertion macros for the point transform block.
// Used by point_rigid_transform_quantize.sv; no other dependencies.
`ifndef POINT_RIGID_TRANSFORM_QUANTIZE_ASSERT_SVH
`define POINT_RIGID_TRANSFORM_QUANTIZE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PRTQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define PRTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/prtq_pkg.sv
// Shared types and constants for the point transform block.
// No dependencies.
`default_nettype none
package prtq_pkg;
  typedef struct packed {
    logic signed [31:0] point_z;
    logic signed [31:0] point_y;
    logic signed [31:0] point_x;
  } prtq_in_t;

  typedef struct packed {
    logic               range_overflow;
    logic signed [31:0] world_z_mm;
    logic signed [31:0] world_y_mm;
    logic signed [31:0] world_x_mm;
  } prtq_out_t;

  typedef enum logic [2:0] {
    REG_ROLL  = 3'd0,
    REG_PITCH = 3'd1,
    REG_YAW   = 3'd2,
    REG_OFFX  = 3'd3,
    REG_OFFY  = 3'd4,
    REG_OFFZ  = 3'd5
  } prtq_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RED, ST_CORD, ST_MUL1, ST_MUL2, ST_MUL3
  } prtq_state_e;

  localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd421657428;
  localparam logic signed [33:0] ANG_TWO_PI  = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

  function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
    logic signed [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'sd210828714;  5'd1: r = 32'sd124459457;
        5'd2: r = 32'sd65760959;   5'd3: r = 32'sd33381290;
        5'd4: r = 32'sd16755422;   5'd5: r = 32'sd8385879;
        5'd6: r = 32'sd4193963;    5'd7: r = 32'sd2097109;
        5'd8: r = 32'sd1048571;    5'd9: r = 32'sd524287;
        default: r = (i < 5'd29) ? (32'sd1 <<< (5'd28 - i)) : 32'sd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// File: hdl/prtq_matrix.sv
// Rotation matrix builder: CORDIC rotators stepped together and a shared multiplier sequencer.
// Depends on prtq_pkg.
`default_nettype none
module prtq_matrix
  import prtq_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] roll,
  input  wire logic signed [31:0] pitch,
  input  wire logic signed [31:0] yaw,
  output logic                    busy,
  output logic signed [31:0]      coef [9]
);
  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  prtq_state_e st_r, st_nxt;
  logic [CW-1:0]      step_r, step_nxt;
  logic [3:0]         mi_r, mi_nxt;
  logic signed [33:0] a_r [3];
  logic               neg_r [3];
  logic signed [33:0] x_r [3], y_r [3], z_r [3];
  logic signed [33:0] c_r [6];   // cr sr cp sp cy sy (Q2.30)
  logic signed [33:0] spsr_r, spcr_r;
  logic signed [33:0] t_r;       // first term of a sum
  logic signed [31:0] coef_r [9];

  assign busy = (st_r != ST_IDLE);
  always_comb for (int k = 0; k < 9; k++) coef[k] = coef_r[k];

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
    step_r <= step_nxt;
    mi_r   <= mi_nxt;
  end

  always_comb begin
    st_nxt = st_r; step_nxt = step_r; mi_nxt = mi_r;
    unique case (st_r)
      ST_IDLE: if (start) st_nxt = ST_RED;
      ST_RED: begin
        // finish once all angles are inside +-pi
        if (a_r[0] <= ANG_PI && a_r[0] >= -ANG_PI && a_r[1] <= ANG_PI &&
            a_r[1] >= -ANG_PI && a_r[2] <= ANG_PI && a_r[2] >= -ANG_PI) begin
          st_nxt = ST_CORD; step_nxt = '0;
        end
      end
      ST_CORD: if (step_r == CW'(CORDIC_STEPS - 1)) begin
        st_nxt = ST_MUL1; mi_nxt = '0;
      end else step_nxt = step_r + 1'b1;
      ST_MUL1: if (mi_r == 4'd1) begin st_nxt = ST_MUL2; mi_nxt = '0; end
               else mi_nxt = mi_r + 1'b1;
      ST_MUL2: if (mi_r == 4'd14) st_nxt = ST_IDLE; else mi_nxt = mi_r + 1'b1;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // one shared 34x34 multiplier; operands picked by sequence index
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [33:0] q;
  always_comb begin
    ma = '0; mb = '0;
    if (st_r == ST_MUL1) begin
      ma = c_r[3]; mb = (mi_r == 4'd0) ? c_r[1] : c_r[0];
    end else begin
      case (mi_r)
        4'd0:  begin ma = c_r[4]; mb = c_r[2]; end
        4'd1:  begin ma = c_r[4]; mb = spsr_r; end
        4'd2:  begin ma = c_r[5]; mb = c_r[0]; end
        4'd3:  begin ma = c_r[4]; mb = spcr_r; end
        4'd4:  begin ma = c_r[5]; mb = c_r[1]; end
        4'd5:  begin ma = c_r[5]; mb = c_r[2]; end
        4'd6:  begin ma = c_r[5]; mb = spsr_r; end
        4'd7:  begin ma = c_r[4]; mb = c_r[0]; end
        4'd8:  begin ma = c_r[5]; mb = spcr_r; end
        4'd9:  begin ma = c_r[4]; mb = c_r[1]; end
        4'd10: begin ma = c_r[2]; mb = c_r[1]; end
        4'd11: begin ma = c_r[2]; mb = c_r[0]; end
        default: begin ma = '0; mb = '0; end
      endcase
    end
    prod = ma * mb + (68'sd1 <<< 29);
    q    = 34'(prod >>> 30);
  end

  function automatic logic signed [31:0] clamp(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7fffffff;
    if (v < -35'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) coef_r[k] <= (k % 4 == 0) ? ONE_Q30 : 32'sd0;
    end else begin
      unique case (st_r)
        ST_IDLE: if (start) begin
          a_r[0] <= 34'(roll); a_r[1] <= 34'(pitch); a_r[2] <= 34'(yaw);
        end
        ST_RED: for (int k = 0; k < 3; k++) begin
          if (a_r[k] > ANG_PI) a_r[k] <= a_r[k] - ANG_TWO_PI;
          else if (a_r[k] < -ANG_PI) a_r[k] <= a_r[k] + ANG_TWO_PI;
          else if (st_nxt == ST_CORD) begin
            x_r[k] <= CORDIC_GAIN; y_r[k] <= '0;
            if (a_r[k] > ANG_HALF_PI) begin z_r[k] <= a_r[k] - ANG_PI; neg_r[k] <= 1'b1; end
            else if (a_r[k] < -ANG_HALF_PI) begin
              z_r[k] <= a_r[k] + ANG_PI; neg_r[k] <= 1'b1;
            end else begin z_r[k] <= a_r[k]; neg_r[k] <= 1'b0; end
          end
        end
        ST_CORD: for (int k = 0; k < 3; k++) begin
          if (st_nxt == ST_MUL1) begin
            // last iteration plus sign fix into cos/sin
            logic signed [33:0] nx, ny;
            if (z_r[k] >= 0) begin
              nx = x_r[k] - (y_r[k] >>> step_r); ny = y_r[k] + (x_r[k] >>> step_r);
            end else begin
              nx = x_r[k] + (y_r[k] >>> step_r); ny = y_r[k] - (x_r[k] >>> step_r);
            end
            c_r[2*k]   <= neg_r[k] ? -nx : nx;
            c_r[2*k+1] <= neg_r[k] ? -ny : ny;
          end else if (z_r[k] >= 0) begin
            x_r[k] <= x_r[k] - (y_r[k] >>> step_r);
            y_r[k] <= y_r[k] + (x_r[k] >>> step_r);
            z_r[k] <= z_r[k] - 34'(atan_q28(5'(step_r)));
          end else begin
            x_r[k] <= x_r[k] + (y_r[k] >>> step_r);
            y_r[k] <= y_r[k] - (x_r[k] >>> step_r);
            z_r[k] <= z_r[k] + 34'(atan_q28(5'(step_r)));
          end
        end
        ST_MUL1: if (mi_r == 4'd0) spsr_r <= q; else spcr_r <= q;
        ST_MUL2: begin
          case (mi_r)
            4'd0:  coef_r[0] <= clamp(35'(q));
            4'd1:  t_r <= q;
            4'd2:  coef_r[1] <= clamp(35'(t_r) - 35'(q));
            4'd3:  t_r <= q;
            4'd4:  coef_r[2] <= clamp(35'(t_r) + 35'(q));
            4'd5:  coef_r[3] <= clamp(35'(q));
            4'd6:  t_r <= q;
            4'd7:  coef_r[4] <= clamp(35'(t_r) + 35'(q));
            4'd8:  t_r <= q;
            4'd9:  coef_r[5] <= clamp(35'(t_r) - 35'(q));
            4'd10: coef_r[7] <= clamp(35'(q));
            4'd11: coef_r[8] <= clamp(35'(q));
            4'd12: coef_r[6] <= clamp(-35'(c_r[3]));
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/point_rigid_transform_quantize.sv
// Top level of the point transform block: config registers and point pipeline.
// Depends on prtq_pkg, prtq_matrix and point_rigid_transform_quantize_assert.svh.
//
// Usage:
//   in_*  : one point (Q16.16 metres) per valid/ready transaction.
//   out_* : one result (millimetres, saturated, with overflow flag) per point.
//   cfg_* : write-only registers; index 0..2 are roll/pitch/yaw (Q4.28 rad),
//           3..5 are offsets (2^-16 m). Indexes above five are dropped.
// Throughput: one point per cycle while the output is not stalled and no matrix rebuild runs.
// The datapath has five stages: multiply, shift-and-sum, scale by
// 1000 (split hi/lo), recombine, apply sign and clamp into the output register.
// An angle write rebuilds the matrix: angle reduction, then three CORDIC
// rotators stepped together, then one shared multiplier. During the
// rebuild in_ready is low; points already inside the pipe finish first.
// Reset: registers clear, matrix is the identity, pipeline empties.
// Stall: when out_valid is high and out_ready is low the whole pipe holds; no transaction is lost.
`default_nettype none
`include "point_rigid_transform_quantize_assert.svh"
module point_rigid_transform_quantize
  import prtq_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire prtq_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output prtq_out_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_wdata
);
  logic signed [31:0] ang_r [3];
  logic signed [47:0] off_r [3];
  logic               mat_busy, mat_start;
  logic signed [31:0] coef [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin ang_r[k] <= '0; off_r[k] <= '0; end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROLL, REG_PITCH, REG_YAW: ang_r[cfg_index[1:0]] <= cfg_wdata[31:0];
        REG_OFFX:  off_r[0] <= cfg_wdata;
        REG_OFFY:  off_r[1] <= cfg_wdata;
        REG_OFFZ:  off_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // start a rebuild the cycle after an angle write, using the new angles
  logic rebuild_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rebuild_r <= 1'b0;
    else rebuild_r <= cfg_we && (cfg_index <= REG_YAW);
  end
  assign mat_start = rebuild_r;

  prtq_matrix #(.CORDIC_STEPS(CORDIC_STEPS)) u_matrix (
    .clk, .rst_n, .start(mat_start),
    .roll(ang_r[0]), .pitch(ang_r[1]), .yaw(ang_r[2]),
    .busy(mat_busy), .coef
  );

  // pipeline: advance whenever the output register is free or draining
  logic adv;
  logic [4:0] v_r;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !mat_busy && !rebuild_r;

  // offset*256 spans 56 bits, so the sum and magnitude paths are sized for it
  logic signed [63:0] p1_r [9];
  logic signed [56:0] s2_r [3];
  logic               n3_r [3];
  logic [32:0]        hi3_r [3];
  logic [33:0]        lom3_r [3];
  logic [43:0]        mag4_r [3];
  logic               n4_r [3];
  prtq_out_t          out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[3:0], in_valid && in_ready};
  end
  assign out_valid = v_r[4];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: nine 32x32 products
      for (int r = 0; r < 3; r++) begin
        p1_r[3*r]   <= coef[3*r]   * in_data.point_x;
        p1_r[3*r+1] <= coef[3*r+1] * in_data.point_y;
        p1_r[3*r+2] <= coef[3*r+2] * in_data.point_z;
      end
      // stage 2: floor shift and sum with offset
      for (int r = 0; r < 3; r++)
        s2_r[r] <= 57'(p1_r[3*r] >>> 22) + 57'(p1_r[3*r+1] >>> 22) +
                   57'(p1_r[3*r+2] >>> 22) + (57'(off_r[r]) <<< 8);
      // stage 3: magnitude split and scale the fraction by 1000
      for (int r = 0; r < 3; r++) begin
        logic [56:0] u;
        u = s2_r[r][56] ? 57'(-s2_r[r]) : 57'(s2_r[r]);
        n3_r[r]   <= s2_r[r][56];
        hi3_r[r]  <= u[56:24];
        lom3_r[r] <= 34'(u[23:0]) * 34'd1000;
      end
      // stage 4: recombine
      for (int r = 0; r < 3; r++) begin
        mag4_r[r] <= 44'(hi3_r[r]) * 44'd1000 + 44'(lom3_r[r][33:24]);
        n4_r[r]   <= n3_r[r];
      end
      // stage 5: sign and clamp
      begin
        logic ov;
        logic signed [31:0] w [3];
        ov = 1'b0;
        for (int r = 0; r < 3; r++) begin
          if (!n4_r[r] && mag4_r[r] > 44'd2147483647) begin
            w[r] = 32'sh7fffffff; ov = 1'b1;
          end else if (n4_r[r] && mag4_r[r] > 44'd2147483648) begin
            w[r] = 32'sh80000000; ov = 1'b1;
          end else w[r] = n4_r[r] ? 32'(-mag4_r[r]) : 32'(mag4_r[r]);
        end
        out_r.world_x_mm     <= w[0];
        out_r.world_y_mm     <= w[1];
        out_r.world_z_mm     <= w[2];
        out_r.range_overflow <= ov;
      end
    end
  end

  `PRTQ_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, mat_busy, !in_ready)
  `PRTQ_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_valid && !out_ready,
                    out_valid && $stable(out_data))
  `PRTQ_ASSERT_NEXT(a_rebuild_starts, clk, rst_n, rebuild_r, mat_busy)
endmodule
`default_nettype wire

// File: tb/point_rigid_transform_quantize_test.sv
// Self-checking bench for point_rigid_transform_quantize: random and directed points
// under changing poses, checked against a built-in fixed-point predictor of the pose math.
// Depends on prtq_pkg and the block's RTL.
`default_nettype none
module point_rigid_transform_quantize_test;
  import prtq_pkg::*;

  localparam int STEPS = 24;
  // Indexes the block must ignore.
  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;
  // Wait before any register write: pipe drain plus one full matrix rebuild.
  localparam int SETTLE_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  prtq_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  prtq_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  point_rigid_transform_quantize #(.CORDIC_STEPS(STEPS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Pose predictor: own copy of the angle/offset registers and the matrix.
  // ---------------------------------------------------------------------------
  logic signed [31:0] pose_angle [3];
  logic signed [47:0] pose_offset [3];
  longint             pose_coef [9];

  longint atan_tab [32] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
    2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

  function automatic longint q30_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint clamp_s32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // CORDIC sine/cosine in Q2.30 of a Q4.28 angle.
  task automatic cordic_sincos(input longint ang, output longint c, output longint s);
    bit     flip;
    longint x, y, z, dx, dy;
    flip = 1'b0;
    x = longint'(CORDIC_GAIN);
    y = 0;
    while (ang > longint'(ANG_PI)) ang -= longint'(ANG_TWO_PI);
    while (ang < -longint'(ANG_PI)) ang += longint'(ANG_TWO_PI);
    if (ang > longint'(ANG_HALF_PI)) begin
      ang -= longint'(ANG_PI);
      flip = 1'b1;
    end else if (ang < -longint'(ANG_HALF_PI)) begin
      ang += longint'(ANG_PI);
      flip = 1'b1;
    end
    z = ang;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic rebuild_pose;
    longint cr, sr, cp, sp, cy, sy, spsr, spcr;
    longint r [9];
    bit     unused_sat;
    unused_sat = 1'b0;
    cordic_sincos(longint'(pose_angle[0]), cr, sr);
    cordic_sincos(longint'(pose_angle[1]), cp, sp);
    cordic_sincos(longint'(pose_angle[2]), cy, sy);
    spsr = q30_mul(sp, sr);
    spcr = q30_mul(sp, cr);
    r[0] = q30_mul(cy, cp);
    r[1] = q30_mul(cy, spsr) - q30_mul(sy, cr);
    r[2] = q30_mul(cy, spcr) + q30_mul(sy, sr);
    r[3] = q30_mul(sy, cp);
    r[4] = q30_mul(sy, spsr) + q30_mul(cy, cr);
    r[5] = q30_mul(sy, spcr) - q30_mul(cy, sr);
    r[6] = -sp;
    r[7] = q30_mul(cp, sr);
    r[8] = q30_mul(cp, cr);
    for (int k = 0; k < 9; k++) pose_coef[k] = clamp_s32(r[k], unused_sat);
  endtask

  // Q.24 metres to millimetres, truncated toward zero.
  function automatic longint q24_to_mm(longint v);
    longint u, mag;
    u = (v < 0) ? -v : v;
    mag = (u >>> 24) * 1000 + (((u & 64'hFFFFFF) * 1000) >>> 24);
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic prtq_out_t transform_point(prtq_in_t p);
    prtq_out_t res;
    longint    pv [3];
    longint    acc;
    bit        sat;
    logic signed [31:0] mm [3];
    sat = 1'b0;
    pv[0] = longint'(p.point_x);
    pv[1] = longint'(p.point_y);
    pv[2] = longint'(p.point_z);
    for (int r = 0; r < 3; r++) begin
      acc = longint'(pose_offset[r]) * 256;
      for (int c = 0; c < 3; c++) acc += (pose_coef[r*3+c] * pv[c]) >>> 22;
      mm[r] = 32'(clamp_s32(q24_to_mm(acc), sat));
    end
    res.world_x_mm = mm[0];
    res.world_y_mm = mm[1];
    res.world_z_mm = mm[2];
    res.range_overflow = sat;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues, counters
  // ---------------------------------------------------------------------------
  prtq_in_t  points_pending [$];
  prtq_out_t world_expected [$];
  int        fail_count = 0;
  int        points_sent = 0;
  int        results_seen = 0;
  int        overflow_seen = 0;
  int        pose_count = 0;

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      // Current transaction (if any) is done; choose what to drive next.
      if (in_valid && in_ready) points_sent <= points_sent + 1;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (points_pending.size() > 0) begin
        in_data  <= points_pending.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: out_ready follows one of four randomly redrawn modes.
  // ---------------------------------------------------------------------------
  int stall_cycle = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 64 == 63) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= (stall_cycle % 5 != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transaction with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    prtq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (out_data.range_overflow) overflow_seen <= overflow_seen + 1;
      if (world_expected.size() == 0) begin
        $error("unexpected result transaction %h", out_data);
        fail_count <= fail_count + 1;
      end else begin
        want = world_expected.pop_front();
        if (out_data.world_x_mm !== want.world_x_mm) begin
          $error("world_x_mm expected %0d actual %0d", want.world_x_mm, out_data.world_x_mm);
          fail_count <= fail_count + 1;
        end
        if (out_data.world_y_mm !== want.world_y_mm) begin
          $error("world_y_mm expected %0d actual %0d", want.world_y_mm, out_data.world_y_mm);
          fail_count <= fail_count + 1;
        end
        if (out_data.world_z_mm !== want.world_z_mm) begin
          $error("world_z_mm expected %0d actual %0d", want.world_z_mm, out_data.world_z_mm);
          fail_count <= fail_count + 1;
        end
        if (out_data.range_overflow !== want.range_overflow) begin
          $error("range_overflow expected %0b actual %0b",
                 want.range_overflow, out_data.range_overflow);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Queue one point and its prediction under the current pose.
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
    prtq_in_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    points_pending.push_back(p);
    world_expected.push_back(transform_point(p));
  endtask

  // Hold until the pipe is empty, then let a rebuild finish.
  task automatic wait_idle;
    while (points_pending.size() > 0 || in_valid || world_expected.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx <= REG_YAW) begin
      pose_angle[idx] = val[31:0];
      rebuild_pose();
    end else if (idx <= REG_OFFZ) begin
      pose_offset[idx - REG_OFFX] = val;
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();                                   // full range
      1: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      2: return 32'($signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000);
      default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
    endcase
  endfunction

  function automatic logic [47:0] rand_offset();
    case ($urandom_range(0, 3))
      0: return {16'($urandom()), 32'($urandom())};           // often saturates
      1: return 48'('0);
      default: return 48'($signed(48'($urandom_range(0, 32'h0FFF_FFFF)) - 48'sh0800_0000));
    endcase
  endfunction

  function automatic logic [47:0] rand_angle();
    if ($urandom_range(0, 2) == 0) return 48'($signed($urandom()));
    return 48'($signed(32'($urandom_range(0, 32'h6400_0000)) - 32'sh3200_0000));
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < 3; k++) begin
      pose_angle[k]  = '0;
      pose_offset[k] = '0;
    end
    for (int k = 0; k < 9; k++) pose_coef[k] = (k % 4 == 0) ? 64'sd1073741824 : 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity pose out of reset: field extremes and sign edges.
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF);
    send_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_0001);
    send_point(32'shFFFF_FFFF, 32'sh0000_0041, -32'sh0000_0041);
    send_point(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh7FFF_FFFF);

    // Offset only: matrix stays the identity; push to both saturation rails.
    write_reg(REG_OFFX, 48'h7FFF_FFFF_FFFF);
    write_reg(REG_OFFY, 48'h8000_0000_0000);
    write_reg(REG_OFFZ, 48'h0000_0001_0000);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
    send_point(32'sh0, 32'sh0, 32'sh8000_0000);
    // Ignored indexes must not disturb anything.
    write_reg(REG_SPARE6, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_SPARE7, 48'h1234_5678_9ABC);
    send_point(32'sh0010_0000, 32'sh0, -32'sh0010_0000);

    // Angle extremes and quadrant edges around +-pi and +-pi/2.
    write_reg(REG_OFFX, 48'h0);
    write_reg(REG_OFFY, 48'h0);
    write_reg(REG_OFFZ, 48'h0);
    write_reg(REG_ROLL, 48'(32'sh7FFF_FFFF));
    write_reg(REG_PITCH, 48'(32'sh8000_0000));
    write_reg(REG_YAW, 48'(ANG_PI));
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    write_reg(REG_ROLL, 48'(-ANG_PI));
    write_reg(REG_PITCH, 48'(ANG_HALF_PI + 1));
    write_reg(REG_YAW, 48'(-ANG_HALF_PI - 1));
    send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    write_reg(REG_ROLL, 48'(ANG_HALF_PI));
    write_reg(REG_PITCH, 48'(-ANG_HALF_PI));
    write_reg(REG_YAW, 48'h0);
    send_point(-32'sh0001_0000, 32'sh0005_8000, 32'sh7FFF_FFFF);
    pose_count = 4;

    // Random poses, with random points under each.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_ROLL, rand_angle());
      write_reg(REG_PITCH, rand_angle());
      write_reg(REG_YAW, rand_angle());
      write_reg(REG_OFFX, rand_offset());
      write_reg(REG_OFFY, rand_offset());
      write_reg(REG_OFFZ, rand_offset());
      if (ph % 4 == 0) write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE6 : REG_SPARE7,
                                 {16'($urandom()), 32'($urandom())});
      pose_count++;
      for (int n = 0; n < 95; n++) send_point(rand_coord(), rand_coord(), rand_coord());
    end

    wait_idle();
    $display("covered %0d poses, %0d points sent, %0d results checked (%0d saturated)",
             pose_count, points_sent, results_seen, overflow_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
